/* rtl/core/isst_pkg.sv */
package isst_pkg;

	localparam int DEF_CAPACITY  = 16;
	localparam int DEF_WORD_BITS = 32;

	// Width for position/count compares; covers counts up to 256 (max CAPACITY)
	localparam int CTL_W = 9;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_GET    = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_EXTEND,
		OP_REMOVE
	} op_t;

	// Broadcast from the controller to every cell of the chain
	typedef struct packed {
		op_t              op;
		logic [CTL_W-1:0] pos;
		logic [CTL_W-1:0] cnt;
	} cell_ctl_t;

endpackage

/* rtl/core/isst_cell.sv */
module isst_cell #(
	parameter int WORD_BITS  = isst_pkg::DEF_WORD_BITS,
	parameter int CELL_INDEX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isst_pkg::cell_ctl_t   ctl,
	input  logic [WORD_BITS-1:0]  ins_word,
	input  logic [WORD_BITS-1:0]  left_word,
	input  logic                  left_pad,
	input  logic [WORD_BITS-1:0]  right_word,
	input  logic                  right_pad,
	output logic [WORD_BITS-1:0]  word,
	output logic                  pad
);
	import isst_pkg::*;

	localparam logic [CTL_W-1:0] IDX = CTL_W'(CELL_INDEX);

	logic [WORD_BITS-1:0] word_q;
	logic                 pad_q;
	logic [WORD_BITS-1:0] word_d;
	logic                 pad_d;
	logic                 load;

	always_comb begin
		word_d = word_q;
		pad_d  = pad_q;
		load   = 1'b0;
		case (ctl.op)
			OP_INSERT: begin
				if (IDX == ctl.pos) begin
					word_d = ins_word;
					pad_d  = 1'b0;
					load   = 1'b1;
				end else if (IDX > ctl.pos && IDX <= ctl.cnt) begin
					word_d = left_word;
					pad_d  = left_pad;
					load   = 1'b1;
				end
			end
			OP_EXTEND: begin
				if (IDX == ctl.pos) begin
					word_d = ins_word;
					pad_d  = 1'b0;
					load   = 1'b1;
				end else if (IDX >= ctl.cnt && IDX < ctl.pos) begin
					word_d = '0;
					pad_d  = 1'b1;
					load   = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (IDX >= ctl.pos && IDX + 1'b1 < ctl.cnt) begin
					word_d = right_word;
					pad_d  = right_pad;
					load   = 1'b1;
				end else if (IDX + 1'b1 == ctl.cnt) begin
					word_d = '0;
					pad_d  = 1'b0;
					load   = 1'b1;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= 1'b0;
		end else begin
			pad_q <= pad_d;
		end
	end

	assign word = word_q;
	assign pad  = pad_q;

endmodule

/* rtl/core/isst_ctrl.sv */
module isst_ctrl #(
	parameter int CAPACITY  = isst_pkg::DEF_CAPACITY,
	parameter int WORD_BITS = isst_pkg::DEF_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [4:0]            position,
	input  logic [WORD_BITS-1:0]  rd_word,
	input  logic                  rd_pad,
	output isst_pkg::cell_ctl_t   ctl,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           data_out,
	output logic                  is_empty,
	output logic [1:0]            status,
	output logic [4:0]            count
);
	import isst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CTL_W-1:0] CAP_C = CTL_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [31:0]      data_q;
	logic             empty_q;
	logic [1:0]       status_q;
	logic [4:0]       count_out_q;

	logic             accept;
	logic [CTL_W-1:0] pos_c;
	logic [CTL_W-1:0] cnt_c;
	logic [CTL_W-1:0] cnt_next;
	op_t              op;
	logic [31:0]      data_d;
	logic             empty_d;
	logic [1:0]       status_d;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign pos_c    = CTL_W'(position);
	assign cnt_c    = CTL_W'(count_q);

	always_comb begin
		op       = OP_HOLD;
		data_d   = '0;
		empty_d  = 1'b0;
		status_d = STAT_OK;
		cnt_next = cnt_c;
		case (kind)
			KIND_INSERT: begin
				if (pos_c <= cnt_c) begin
					if (cnt_c >= CAP_C) begin
						status_d = STAT_FULL;
					end else begin
						op       = OP_INSERT;
						cnt_next = cnt_c + 1'b1;
					end
				end else if (pos_c >= CAP_C) begin
					status_d = STAT_FULL;
				end else begin
					op       = OP_EXTEND;
					cnt_next = pos_c + 1'b1;
				end
			end
			KIND_REMOVE, KIND_GET: begin
				if (pos_c >= cnt_c) begin
					status_d = STAT_RANGE;
				end else begin
					for (int b = 0; b < 32; b++) begin
						if (b < WORD_BITS) begin
							data_d[b] = rd_word[b];
						end
					end
					empty_d = rd_pad;
					if (kind == KIND_REMOVE) begin
						op       = OP_REMOVE;
						cnt_next = cnt_c - 1'b1;
					end
				end
			end
			default: begin
				op = OP_HOLD;
			end
		endcase
	end

	always_comb begin
		ctl.op  = accept ? op : OP_HOLD;
		ctl.pos = pos_c;
		ctl.cnt = cnt_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= cnt_next[CNT_W-1:0];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q      <= data_d;
			empty_q     <= empty_d;
			status_q    <= status_d;
			count_out_q <= cnt_next[4:0];
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign is_empty  = empty_q;
	assign status    = status_q;
	assign count     = count_out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CTL_W'(count_q) <= CAP_C)
		else $error("entry count exceeds capacity");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d == STAT_FULL |=> $stable(count_q))
		else $error("count changed on a full insert");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_REMOVE |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not shrink count");

	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request produced no result");
`endif

endmodule

/* rtl/core/indexed_sequence_store.sv */
// Channel | handshake            | payload
// --------+----------------------+-------------------------------------
// request | in_valid / in_ready  | kind, position, value
// result  | out_valid / out_ready| data_out, is_empty, status, count
//
// One request per cycle: every cell of the chain shifts, loads or holds in the
// same cycle, so throughput is set by the result register, one deep.
// The result is registered: out_valid rises in the cycle after the request is accepted.
// in_ready drops only while a result waits and out_ready is low.
// arst_n clears the count, the padding flags and the result valid; words are
// not reset.
module indexed_sequence_store #(
	parameter int CAPACITY  = isst_pkg::DEF_CAPACITY,
	parameter int WORD_BITS = isst_pkg::DEF_WORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] data_out,
	output logic        is_empty,
	output logic [1:0]  status,
	output logic [4:0]  count
);
	import isst_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	cell_ctl_t            ctl;
	logic [WORD_BITS-1:0] ins_word;
	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic                 cell_pad  [CAPACITY];
	logic [CTL_W-1:0]     pos_c;
	logic [WORD_BITS-1:0] rd_word;
	logic                 rd_pad;

	// mask the request word to the stored width
	always_comb begin
		ins_word = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (b < 32) begin
				ins_word[b] = value[b];
			end
		end
	end

	assign pos_c   = CTL_W'(position);
	assign rd_word = cell_word[pos_c[IDX_W-1:0]];
	assign rd_pad  = cell_pad[pos_c[IDX_W-1:0]];

	isst_ctrl #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.position  (position),
		.rd_word   (rd_word),
		.rd_pad    (rd_pad),
		.ctl       (ctl),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.is_empty  (is_empty),
		.status    (status),
		.count     (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] lw;
		logic                 lp;
		logic [WORD_BITS-1:0] rw;
		logic                 rp;

		if (i == 0) begin : g_first
			assign lw = '0;
			assign lp = 1'b0;
		end else begin : g_mid_l
			assign lw = cell_word[i-1];
			assign lp = cell_pad[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rw = '0;
			assign rp = 1'b0;
		end else begin : g_mid_r
			assign rw = cell_word[i+1];
			assign rp = cell_pad[i+1];
		end

		isst_cell #(
			.WORD_BITS  (WORD_BITS),
			.CELL_INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ins_word   (ins_word),
			.left_word  (lw),
			.left_pad   (lp),
			.right_word (rw),
			.right_pad  (rp),
			.word       (cell_word[i]),
			.pad        (cell_pad[i])
		);
	end

endmodule
